[rtl/assert_macros.svh]
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[rtl/swmf_pkg.sv]
package swmf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int HALF_WIDTH_DEFAULT = 15;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type sample;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      sample_type median;
      logic       last;
      logic       short_frame;
   } rsp_type;

   // What one sorting cell shows to its two neighbors.
   typedef struct packed {
      logic       valid;
      logic       eq;
      logic       up;
      logic       down;
      sample_type val;
   } cell_link_type;

endpackage

[rtl/swmf_cell.sv]
module swmf_cell
   import swmf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          clear,
   input  logic          full,
   input  sample_type    ins_val,
   input  sample_type    old_val,
   input  cell_link_type from_left,
   input  cell_link_type from_right,
   output cell_link_type link
);

   logic       valid_ff, valid_in;
   sample_type val_ff, val_in;
   logic       goes_after_new, after_old, eq_old, del, before_old, keep;

   // Ties are kept youngest first, so the oldest copy of a value is the last of its run.
   assign goes_after_new = !valid_ff || ($signed(val_ff) >= $signed(ins_val));
   assign after_old      = full && valid_ff && ($signed(val_ff) > $signed(old_val));
   assign eq_old         = full && valid_ff && (val_ff == old_val);
   assign del            = eq_old && !from_right.eq;
   assign before_old     = !after_old && !del;
   assign keep           = (before_old && !goes_after_new) || (after_old && goes_after_new);

   always_comb begin
      if (keep) begin
         val_in = val_ff;
      end else if (from_right.down) begin
         val_in = from_right.val;
      end else if (from_left.up) begin
         val_in = from_left.val;
      end else begin
         val_in = ins_val;
      end
   end

   assign valid_in = clear ? 1'b0 : (valid_ff || from_left.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         val_ff <= val_in;
      end
   end

   assign link.valid = valid_ff;
   assign link.eq    = eq_old;
   assign link.up    = before_old && goes_after_new;
   assign link.down  = after_old && !goes_after_new;
   assign link.val   = val_ff;

endmodule

[rtl/sliding_window_median_filter_top.sv]
// An accepted beat sets the pending count, and its results then load into the free result register.
// Throughput: one sample per cycle in steady state with rsp_ready high, one result each; the
// sample that fills the window gives HALF_WIDTH+1 results, a full-window frame end adds
// HALF_WIDTH more, and the input waits while a burst drains through the single result register.
// Reset (synchronous, active high) empties the sorting row, the fill count and the result
// register; sample values themselves are not cleared.
`include "assert_macros.svh"

module sliding_window_median_filter_top
   import swmf_pkg::*;
#(
   parameter int HALF_WIDTH = HALF_WIDTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int WIN      = 2 * HALF_WIDTH + 1;
   localparam int CNT_BITS = $clog2(WIN + 1);

   // Fill count of the current frame, saturating at the window length.
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   // Results of the current beat still to be loaded into the result register.
   logic [CNT_BITS-1:0] rem_ff, rem_in, reps;
   logic                end_pend_ff, end_pend_in;
   logic                short_pend_ff, short_pend_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Arrival-order shift line; entry 0 is the oldest sample of a full window.
   sample_type          win_ff [WIN];

   logic                accept, load, full, just_full, win_ok;
   cell_link_type       links [WIN];

   assign full      = (fill_ff == CNT_BITS'(WIN));
   assign just_full = (fill_ff == CNT_BITS'(WIN - 1));
   assign win_ok    = full || just_full;

   // The result register takes a new result when it is empty or being drained.
   assign load      = (rem_ff != '0) && (!rsp_valid_ff || rsp_ready);
   // A new beat may enter while the last result of the previous one is being loaded,
   // since that load still reads the sorting row as it stands before this edge.
   assign req_ready = (rem_ff == '0) || ((rem_ff == CNT_BITS'(1)) && load);
   assign accept    = req_valid && req_ready;

   // Number of results the incoming beat causes.
   always_comb begin
      if (win_ok) begin
         reps = just_full ? CNT_BITS'(HALF_WIDTH + 1) : CNT_BITS'(1);
         if (req_data.frame_end) begin
            reps = reps + CNT_BITS'(HALF_WIDTH);
         end
      end else begin
         reps = req_data.frame_end ? CNT_BITS'(1) : CNT_BITS'(0);
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      rem_in        = rem_ff;
      end_pend_in   = end_pend_ff;
      short_pend_in = short_pend_ff;
      if (load) begin
         rem_in = rem_ff - CNT_BITS'(1);
      end
      if (accept) begin
         rem_in        = reps;
         end_pend_in   = req_data.frame_end;
         short_pend_in = req_data.frame_end && !win_ok;
         if (req_data.frame_end) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + CNT_BITS'(1);
         end
      end
   end

   // The median is the value held by the middle cell of the sorted row, or zero for a short frame.
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_in.median      = short_pend_ff ? sample_type'(0) : links[HALF_WIDTH].val;
         rsp_in.last        = end_pend_ff && (rem_ff == CNT_BITS'(1));
         rsp_in.short_frame = short_pend_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rem_ff        <= '0;
         end_pend_ff   <= 1'b0;
         short_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rem_ff        <= rem_in;
         end_pend_ff   <= end_pend_in;
         short_pend_ff <= short_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         for (int i = 0; i < WIN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN-1] <= req_data.sample;
      end
   end

   // Row of sorting cells: each beat inserts the new sample and, once the window is full,
   // removes the oldest, with every cell taking its own value or one from a neighbor.
   for (genvar g = 0; g < WIN; g++) begin : g_cell
      cell_link_type left_link, right_link;

      if (g == 0) begin : g_left_edge
         assign left_link = '{valid: 1'b1, eq: 1'b0, up: 1'b0, down: 1'b0, val: '0};
      end else begin : g_left
         assign left_link = links[g-1];
      end

      if (g == WIN - 1) begin : g_right_edge
         assign right_link = '{valid: 1'b0, eq: 1'b0, up: 1'b0, down: 1'b0, val: '0};
      end else begin : g_right
         assign right_link = links[g+1];
      end

      swmf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (accept),
         .clear      (req_data.frame_end),
         .full       (full),
         .ins_val    (req_data.sample),
         .old_val    (win_ff[0]),
         .from_left  (left_link),
         .from_right (right_link),
         .link       (links[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A short frame result is always the closing result and carries a zero median.
   `ASSERT_ALWAYS(a_short_is_last, clock, reset,
      (rsp_valid && rsp_data.short_frame) |-> (rsp_data.last && (rsp_data.median == '0)),
      "short frame result without last or with nonzero median")
   // No beat ever queues more results than one full window burst.
   `ASSERT_NEVER(a_rem_bound, clock, reset, rem_ff > CNT_BITS'(WIN),
      "pending result count exceeds the window length")
   // A beat that completes a window or closes a frame leaves results pending.
   `ASSERT_ALWAYS(a_beat_gives_results, clock, reset,
      (accept && (req_data.frame_end || win_ok)) |=> (rem_ff != '0),
      "beat that must produce results left nothing pending")
   // The fill count resets after every frame end.
   `ASSERT_ALWAYS(a_fill_restart, clock, reset,
      (accept && req_data.frame_end) |=> (fill_ff == '0),
      "fill count not cleared after frame end")

endmodule
